FILE: hdl/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants for the serial frame deframer.
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hAA;
  localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h55;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 1'b1;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_END_OK  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END_BAD = 2'd2;

  typedef enum logic [2:0] {
    PH_SYNC1   = 3'd0,
    PH_SYNC2   = 3'd1,
    PH_TYPE    = 3'd2,
    PH_LEN     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CHECK   = 3'd5
  } phase_t;

  typedef struct packed {
    logic              valid;
    logic [KIND_W-1:0] result_kind;
    logic [BYTE_W-1:0] frame_type;
    logic [BYTE_W-1:0] data_byte;
    logic [BYTE_W-1:0] byte_index;
    logic              is_last_payload;
    logic [BYTE_W-1:0] frame_length;
  } result_t;

endpackage

FILE: hdl/sfd_parser.sv
// ----------------------------------------------------------------------------
// sfd_parser
// Frame parse state machine: one byte per step, at most one result per byte.
// ----------------------------------------------------------------------------
module sfd_parser import sfd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [BYTE_W-1:0] rx_byte,
  input  logic [BYTE_W-1:0] sync_first,
  input  logic [BYTE_W-1:0] sync_second,
  output result_t           res
);

  phase_t            phase_r, phase_nxt;
  logic [BYTE_W-1:0] type_r, type_nxt;
  logic [BYTE_W-1:0] len_r, len_nxt;
  logic [BYTE_W-1:0] seen_r, seen_nxt;
  logic [BYTE_W-1:0] xor_r, xor_nxt;
  logic [BYTE_W:0]   seen_inc;
  logic              last;

  assign seen_inc = {1'b0, seen_r} + {{BYTE_W{1'b0}}, 1'b1};
  assign last     = (seen_inc >= {1'b0, len_r});

  always_comb begin
    phase_nxt = phase_r;
    type_nxt  = type_r;
    len_nxt   = len_r;
    seen_nxt  = seen_r;
    xor_nxt   = xor_r;

    res                 = '0;
    res.frame_type      = type_r;
    res.frame_length    = len_r;

    unique case (phase_r)
      PH_SYNC2: begin
        if (rx_byte == sync_second) begin
          xor_nxt   = xor_r ^ rx_byte;
          phase_nxt = PH_TYPE;
        end else begin
          phase_nxt = PH_SYNC1;
        end
      end
      PH_TYPE: begin
        type_nxt  = rx_byte;
        xor_nxt   = xor_r ^ rx_byte;
        phase_nxt = PH_LEN;
      end
      PH_LEN: begin
        len_nxt   = rx_byte;
        seen_nxt  = '0;
        xor_nxt   = xor_r ^ rx_byte;
        // zero length skips straight to the checksum
        phase_nxt = (rx_byte == '0) ? PH_CHECK : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        xor_nxt             = xor_r ^ rx_byte;
        res.valid           = 1'b1;
        res.result_kind     = KIND_PAYLOAD;
        res.data_byte       = rx_byte;
        res.byte_index      = seen_r;
        res.is_last_payload = last;
        seen_nxt            = seen_inc[BYTE_W-1:0];
        if (last) begin
          phase_nxt = PH_CHECK;
        end
      end
      PH_CHECK: begin
        res.valid       = 1'b1;
        res.result_kind = (xor_r == rx_byte) ? KIND_END_OK : KIND_END_BAD;
        phase_nxt       = PH_SYNC1;
      end
      default: begin
        // waiting for first sync; unused codes behave the same
        if (rx_byte == sync_first) begin
          xor_nxt   = rx_byte;
          phase_nxt = PH_SYNC2;
        end else begin
          phase_nxt = PH_SYNC1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SYNC1;
      type_r  <= '0;
      len_r   <= '0;
      seen_r  <= '0;
      xor_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      type_r  <= type_nxt;
      len_r   <= len_nxt;
      seen_r  <= seen_nxt;
      xor_r   <= xor_nxt;
    end
  end

endmodule

FILE: hdl/serial_frame_deframer.sv
// ----------------------------------------------------------------------------
// serial_frame_deframer
// Finds sync/type/length/payload/XOR-checksum frames in a byte stream.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_ready    in_rx_byte
//   out_     output     out_valid / out_ready  kind, type, data, index, last, length
//   cfg_     input      cfg_we                 cfg_index, cfg_wdata
//
// One byte per cycle while no result is held back: a byte waits in the input
// register while the parse logic updates the frame state and loads the result
// register. Reset (rst_n low, synchronous) returns the parser to the sync
// search and loads the default sync values. A byte that yields no result
// never waits on out_ready; a byte with a result waits only while the result
// register is full and not being taken.
// ----------------------------------------------------------------------------
module serial_frame_deframer import sfd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [BYTE_W-1:0]    in_rx_byte,

  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [KIND_W-1:0]    out_result_kind,
  output logic [BYTE_W-1:0]    out_frame_type,
  output logic [BYTE_W-1:0]    out_data_byte,
  output logic [BYTE_W-1:0]    out_byte_index,
  output logic                 out_is_last_payload,
  output logic [BYTE_W-1:0]    out_frame_length,

  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_wdata
);

  logic [BYTE_W-1:0] sync_first_r;
  logic [BYTE_W-1:0] sync_second_r;

  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;

  result_t           res;
  result_t           out_r;
  logic              out_valid_r;
  logic              advance;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= SYNC_FIRST_RST;
      sync_second_r <= SYNC_SECOND_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SYNC_FIRST:  sync_first_r  <= cfg_wdata;
        CFG_SYNC_SECOND: sync_second_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // advance the held byte unless its result would overwrite an untaken beat
  assign advance  = s1_valid_r && (!out_valid_r || out_ready || !res.valid);
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  sfd_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (advance),
    .rx_byte     (s1_byte_r),
    .sync_first  (sync_first_r),
    .sync_second (sync_second_r),
    .res         (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      out_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_result_kind     = out_r.result_kind;
  assign out_frame_type      = out_r.frame_type;
  assign out_data_byte       = out_r.data_byte;
  assign out_byte_index      = out_r.byte_index;
  assign out_is_last_payload = out_r.is_last_payload;
  assign out_frame_length    = out_r.frame_length;

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for serial_frame_deframer. Feeds byte streams of sync,
// type, length, payload and XOR checksum frames mixed with noise and broken
// frames, predicts every payload and frame-end beat, and compares each
// returned beat against the oldest prediction under random stalls.
// ----------------------------------------------------------------------------
module tb import sfd_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] ftype;
    logic [BYTE_W-1:0] data;
    logic [BYTE_W-1:0] index;
    logic              last;
    logic [BYTE_W-1:0] flen;
  } result_beat_t;

  // Frame tracker and queue of beats still owed by the block
  class deframer_board;
    logic [BYTE_W-1:0] sync_a;
    logic [BYTE_W-1:0] sync_b;
    phase_t            phase;
    logic [BYTE_W-1:0] held_type;
    logic [BYTE_W-1:0] held_len;
    logic [BYTE_W-1:0] seen;
    logic [BYTE_W-1:0] sum;
    result_beat_t      owed[$];
    int                errors;

    function new();
      sync_a    = SYNC_FIRST_RST;
      sync_b    = SYNC_SECOND_RST;
      phase     = PH_SYNC1;
      held_type = '0;
      held_len  = '0;
      seen      = '0;
      sum       = '0;
      errors    = 0;
    endfunction

    function void set_sync(input logic [BYTE_W-1:0] a, input logic [BYTE_W-1:0] b);
      sync_a = a;
      sync_b = b;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    function void note_byte(input logic [BYTE_W-1:0] c);
      result_beat_t beat;
      logic         last;
      beat.kind  = KIND_PAYLOAD;
      beat.ftype = held_type;
      beat.data  = '0;
      beat.index = '0;
      beat.last  = 1'b0;
      beat.flen  = held_len;
      case (phase)
        PH_SYNC2: begin
          if (c == sync_b) begin
            sum   = sum ^ c;
            phase = PH_TYPE;
          end else begin
            phase = PH_SYNC1;
          end
        end
        PH_TYPE: begin
          held_type = c;
          sum       = sum ^ c;
          phase     = PH_LEN;
        end
        PH_LEN: begin
          held_len = c;
          seen     = '0;
          sum      = sum ^ c;
          phase    = (c == '0) ? PH_CHECK : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          last       = ({1'b0, seen} + 9'd1) >= {1'b0, held_len};
          sum        = sum ^ c;
          beat.data  = c;
          beat.index = seen;
          beat.last  = last;
          owed.insert(owed.size(), beat);
          seen = seen + 8'd1;
          if (last) begin
            phase = PH_CHECK;
          end
        end
        PH_CHECK: begin
          beat.kind = (sum == c) ? KIND_END_OK : KIND_END_BAD;
          owed.insert(owed.size(), beat);
          phase = PH_SYNC1;
        end
        default: begin
          // unused phase codes behave as the first sync search
          if (c == sync_a) begin
            sum   = c;
            phase = PH_SYNC2;
          end else begin
            phase = PH_SYNC1;
          end
        end
      endcase
    endfunction

    function void check_result(input result_beat_t got);
      result_beat_t want;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("unexpected beat: kind %0d type %02h data %02h idx %0d last %0d len %0d",
                   got.kind, got.ftype, got.data, got.index, got.last, got.flen);
        end
      end else begin
        want = owed[0];
        owed.delete(0);
        if (want.kind !== got.kind || want.ftype !== got.ftype || want.data !== got.data ||
            want.index !== got.index || want.last !== got.last || want.flen !== got.flen) begin
          errors++;
          if (errors <= 10) begin
            $display("beat mismatch: want kind %0d type %02h data %02h idx %0d last %0d len %0d",
                     want.kind, want.ftype, want.data, want.index, want.last, want.flen);
            $display("               got  kind %0d type %02h data %02h idx %0d last %0d len %0d",
                     got.kind, got.ftype, got.data, got.index, got.last, got.flen);
          end
        end
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [BYTE_W-1:0]    in_rx_byte;
  logic                 out_valid;
  logic                 out_ready;
  logic [KIND_W-1:0]    out_result_kind;
  logic [BYTE_W-1:0]    out_frame_type;
  logic [BYTE_W-1:0]    out_data_byte;
  logic [BYTE_W-1:0]    out_byte_index;
  logic                 out_is_last_payload;
  logic [BYTE_W-1:0]    out_frame_length;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BYTE_W-1:0]    cfg_wdata;

  deframer_board     board;
  int                snd_idle = 38;
  int                rcv_idle = 84;
  int                n_sent = 0;
  logic [BYTE_W-1:0] cur_s1 = SYNC_FIRST_RST;
  logic [BYTE_W-1:0] cur_s2 = SYNC_SECOND_RST;
  logic [BYTE_W-1:0] body[$];

  serial_frame_deframer dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_result_kind     (out_result_kind),
    .out_frame_type      (out_frame_type),
    .out_data_byte       (out_data_byte),
    .out_byte_index      (out_byte_index),
    .out_is_last_payload (out_is_last_payload),
    .out_frame_length    (out_frame_length),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  // Take result beats and pick the next stall
  always @(posedge clk) begin : result_sink
    result_beat_t got;
    if (rst_n && out_valid && out_ready) begin
      got.kind  = out_result_kind;
      got.ftype = out_frame_type;
      got.data  = out_data_byte;
      got.index = out_byte_index;
      got.last  = out_is_last_payload;
      got.flen  = out_frame_length;
      board.check_result(got);
    end
    out_ready <= ($urandom_range(0, 99) >= rcv_idle);
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(0, 99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_byte(b);
    n_sent++;
  endtask

  // Hold the sender until every owed beat has come back
  task automatic hold_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic drain();
    hold_for_results();
    // bytes without a result may still be in the pipeline
    repeat (4) @(posedge clk);
  endtask

  task automatic set_syncs(input logic [BYTE_W-1:0] a, input logic [BYTE_W-1:0] b);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SYNC_FIRST;
    cfg_wdata <= a;
    @(posedge clk);
    cfg_index <= CFG_SYNC_SECOND;
    cfg_wdata <= b;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_s1 = a;
    cur_s2 = b;
    board.set_sync(a, b);
  endtask

  // Send one frame carrying the bytes in body
  task automatic send_frame(input logic [BYTE_W-1:0] typ, input bit bad);
    logic [BYTE_W-1:0] len;
    logic [BYTE_W-1:0] sum;
    len = BYTE_W'(body.size());
    sum = cur_s1 ^ cur_s2 ^ typ ^ len;
    foreach (body[i]) sum = sum ^ body[i];
    if (bad) begin
      sum = sum ^ BYTE_W'($urandom_range(1, 255));
    end
    send_byte(cur_s1);
    send_byte(cur_s2);
    send_byte(typ);
    send_byte(len);
    foreach (body[i]) send_byte(body[i]);
    send_byte(sum);
  endtask

  task automatic random_frame(input bit bad);
    int len;
    len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 6) : $urandom_range(7, 40);
    body.delete();
    repeat (len) body.insert(body.size(), BYTE_W'($urandom));
    send_frame(BYTE_W'($urandom), bad);
  endtask

  task automatic run_random(input int budget);
    int                stop;
    int                pick;
    bit                paused;
    logic [BYTE_W-1:0] w;
    stop   = n_sent + budget;
    paused = 1'b0;
    while (n_sent < stop) begin
      if (!paused && n_sent >= stop - budget / 2) begin
        hold_for_results();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        random_frame($urandom_range(0, 9) == 0);
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 4)) send_byte(BYTE_W'($urandom));
      end else if (pick < 90) begin
        // broken second sync
        w = BYTE_W'($urandom);
        if (w == cur_s2) begin
          w = ~w;
        end
        send_byte(cur_s1);
        send_byte(w);
      end else begin
        send_byte(cur_s1);
        send_byte(cur_s1);
      end
    end
  endtask

  initial begin
    logic [BYTE_W-1:0] w;
    board = new();
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_rx_byte <= '0;
    out_ready  <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_index  <= CFG_SYNC_FIRST;
    cfg_wdata  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: zero length, second sync not retested as first, extremes, bad checksums
    body.delete();
    send_frame(8'h00, 1'b0);
    send_byte(cur_s1);
    send_byte(cur_s1);
    send_byte(cur_s2);
    body = '{8'h00, 8'hFF};
    send_frame(8'hFF, 1'b1);
    body = '{8'h80};
    send_frame(8'h5A, 1'b0);
    body.delete();
    send_frame(8'h01, 1'b1);

    drain();
    set_syncs(8'h00, 8'hFF);
    run_random(30);

    drain();
    snd_idle = 84;
    rcv_idle = 38;
    set_syncs(8'hFF, 8'h00);
    run_random(30);

    drain();
    set_syncs(BYTE_W'($urandom), BYTE_W'($urandom));
    run_random(30);

    drain();
    snd_idle = 0;
    rcv_idle = 0;
    w = BYTE_W'($urandom);
    set_syncs(w, w);
    run_random(30);
    // longest payload reaches the top byte index
    body.delete();
    repeat (255) body.insert(body.size(), BYTE_W'($urandom));
    send_frame(BYTE_W'($urandom), 1'b0);

    drain();
    if (board.errors == 0 && board.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: serial_frame_deframer.f
hdl/sfd_pkg.sv
hdl/sfd_parser.sv
hdl/serial_frame_deframer.sv
bench/tb.sv
